[rtl/core/imucal_pkg.sv]
// imucal_pkg: shared types and constants of the IMU startup offset calibrator.
// Used by every module under rtl/core; depends on nothing.
package imucal_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 24;
    localparam int LANES      = 8;
    localparam int AXES       = 6;
    localparam int LANE_W     = 3;
    localparam int SQ_W       = 32;
    localparam int ROOT_STEPS = 16;

    localparam logic [SQ_W-1:0] ROOT_FIRST_BIT = 32'h4000_0000;

    localparam logic [LANE_W-1:0] LANE_GYRO_X  = 3'd0;
    localparam logic [LANE_W-1:0] LANE_ACCEL_X = 3'd3;
    localparam logic [LANE_W-1:0] LANE_ACCEL_Y = 3'd4;
    localparam logic [LANE_W-1:0] LANE_ACCEL_Z = 3'd5;
    localparam logic [LANE_W-1:0] LANE_TILT_X  = 3'd6;
    localparam logic [LANE_W-1:0] LANE_TILT_Y  = 3'd7;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] gyro_x;
        logic signed [SAMPLE_W-1:0] gyro_y;
        logic signed [SAMPLE_W-1:0] gyro_z;
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic signed [SAMPLE_W-1:0] tilt_x;
        logic signed [SAMPLE_W-1:0] tilt_y;
    } imucal_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] gyro_bias_x;
        logic signed [SAMPLE_W-1:0] gyro_bias_y;
        logic signed [SAMPLE_W-1:0] gyro_bias_z;
        logic signed [SAMPLE_W-1:0] accel_bias_x;
        logic signed [SAMPLE_W-1:0] accel_bias_y;
        logic signed [SAMPLE_W-1:0] accel_bias_z;
        logic        [SAMPLE_W-1:0] gravity_norm;
        logic signed [SAMPLE_W-1:0] tilt_bias_x;
        logic signed [SAMPLE_W-1:0] tilt_bias_y;
        logic                       rate_done;
        logic                       all_done;
    } imucal_out_t;

    typedef logic [LANES-1:0][SUM_W-1:0]    sum_vec_t;
    typedef logic [LANES-1:0][SAMPLE_W-1:0] lane_vec_t;
    typedef logic [2:0][SAMPLE_W-1:0]       accel_vec_t;

    typedef struct packed {
        logic             start;
        logic [LANES-1:0] lane_en;
    } imucal_acc_ctrl_t;

    typedef struct packed {
        logic add_rate;
        logic add_tilt;
        logic rate_ends;
        logic angle_ends;
    } imucal_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SQRT_START,
        ST_SQRT_WAIT,
        ST_PUSH
    } imucal_state_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_MUL,
        SQ_ROOT
    } imucal_sq_state_t;

endpackage

[rtl/core/imu_startup_offset_calibrator_core.sv]
// IMU startup offset calibrator, top level. One request in flight at a time.
// Ordinary request: accept, one bit-serial pass over the 24-bit sums, then push of the
// result; the next request is taken only after that push. The tick that ends phase
// one adds six serial divides, then the gravity unit (48 square steps, 16 root
// steps); the tick that ends phase two adds two serial divides.
// Reset (rst_n low, asynchronous) reloads the countdowns, clears sums, means and flags.
module imu_startup_offset_calibrator_core
    import imucal_pkg::*;
#(
    parameter int SAMPLE_COUNT     = 100,
    parameter int ANGLE_LEAD_TICKS = 400
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  imucal_in_t  sample,
    output logic        result_valid,
    input  logic        result_stall,
    output imucal_out_t result
);

    localparam int RATE_W  = $clog2(SAMPLE_COUNT + 1);
    localparam int ANGLE_W = $clog2(ANGLE_LEAD_TICKS + 1);
    localparam int CMP_W   = (RATE_W > ANGLE_W) ? RATE_W : ANGLE_W;
    localparam logic [CMP_W-1:0]   SAMPLE_CMP  = CMP_W'(SAMPLE_COUNT);
    localparam logic [RATE_W-1:0]  RATE_INIT   = RATE_W'(SAMPLE_COUNT);
    localparam logic [ANGLE_W-1:0] ANGLE_INIT  = ANGLE_W'(ANGLE_LEAD_TICKS);

    imucal_state_t       state_reg;
    imucal_state_t       state_next;
    logic [RATE_W-1:0]   rate_cnt_reg;
    logic [ANGLE_W-1:0]  angle_cnt_reg;
    logic [RATE_W-1:0]   rate_dec;
    logic [ANGLE_W-1:0]  angle_dec;
    logic                rate_fin_reg;
    logic                angle_fin_reg;
    logic                phase2;
    imucal_job_t         job;
    imucal_job_t         job_reg;
    logic [LANE_W-1:0]   lane_reg;
    logic [LANES-1:0][SAMPLE_W-1:0] mean_reg;
    logic [SAMPLE_W-1:0] gravity_reg;
    imucal_out_t         result_reg;
    logic                result_valid_reg;
    logic                accept;
    logic                push;

    imucal_acc_ctrl_t    acc_ctrl;
    logic                acc_busy;
    sum_vec_t            sums;
    logic                div_start;
    logic                div_busy;
    logic                div_done;
    logic [SAMPLE_W-1:0] div_quot;
    logic                sq_start;
    logic                sq_busy;
    logic                sq_done;
    logic [SAMPLE_W-1:0] sq_root;
    accel_vec_t          accel_means;

    assign accept = sample_valid && !sample_stall;

    // Decide what this request contributes before it enters the serial adders.
    always_comb
    begin
        rate_dec = rate_cnt_reg;
        if (!rate_fin_reg && rate_cnt_reg != '0)
        begin
            rate_dec = rate_cnt_reg - 1'b1;
        end
        job.add_rate  = !rate_fin_reg;
        job.rate_ends = !rate_fin_reg && (rate_dec == '0);
        phase2        = (rate_fin_reg || job.rate_ends) && !angle_fin_reg;
        angle_dec     = angle_cnt_reg;
        if (phase2 && angle_cnt_reg != '0)
        begin
            angle_dec = angle_cnt_reg - 1'b1;
        end
        // Tilt sums only cover the last SAMPLE_COUNT ticks of the countdown.
        job.add_tilt   = phase2 && (CMP_W'(angle_dec) < SAMPLE_CMP);
        job.angle_ends = job.add_tilt && (angle_dec == '0);
    end

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                if (!acc_busy)
                begin
                    if (job_reg.rate_ends || job_reg.angle_ends)
                    begin
                        state_next = ST_DIV_START;
                    end
                    else
                    begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (lane_reg == LANE_ACCEL_Z)
                    begin
                        state_next = ST_SQRT_START;
                    end
                    else if (lane_reg == LANE_TILT_Y)
                    begin
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_SQRT_START: state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT:
            begin
                if (sq_done)
                begin
                    state_next = job_reg.angle_ends ? ST_DIV_START : ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb
    begin
        sample_stall     = (state_reg != ST_IDLE);
        acc_ctrl.start   = (state_reg == ST_IDLE) && sample_valid;
        acc_ctrl.lane_en = {{(LANES - AXES){job.add_tilt}}, {AXES{job.add_rate}}};
        div_start        = (state_reg == ST_DIV_START);
        sq_start         = (state_reg == ST_SQRT_START);
        push             = (state_reg == ST_PUSH) && (!result_valid_reg || !result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rate_cnt_reg     <= RATE_INIT;
            angle_cnt_reg    <= ANGLE_INIT;
            rate_fin_reg     <= 1'b0;
            angle_fin_reg    <= 1'b0;
            job_reg          <= '0;
            lane_reg         <= LANE_GYRO_X;
            mean_reg         <= '0;
            gravity_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Advance the countdowns and latch the done flags at accept.
            if (accept)
            begin
                rate_cnt_reg  <= rate_dec;
                angle_cnt_reg <= angle_dec;
                rate_fin_reg  <= rate_fin_reg | job.rate_ends;
                angle_fin_reg <= angle_fin_reg | job.angle_ends;
                job_reg       <= job;
            end
            if (state_reg == ST_ACCUM && !acc_busy)
            begin
                lane_reg <= job_reg.rate_ends ? LANE_GYRO_X : LANE_TILT_X;
            end
            else if (state_reg == ST_DIV_WAIT && div_done)
            begin
                mean_reg[lane_reg] <= div_quot;
                lane_reg           <= lane_reg + 1'b1;
            end
            else if (state_reg == ST_SQRT_WAIT && sq_done)
            begin
                gravity_reg <= sq_root;
                lane_reg    <= LANE_TILT_X;
            end
            // Hold the result until taken; drop valid once it leaves.
            if (push)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            result_reg.gyro_bias_x  <= mean_reg[0];
            result_reg.gyro_bias_y  <= mean_reg[1];
            result_reg.gyro_bias_z  <= mean_reg[2];
            result_reg.accel_bias_x <= mean_reg[LANE_ACCEL_X];
            result_reg.accel_bias_y <= mean_reg[LANE_ACCEL_Y];
            result_reg.accel_bias_z <= mean_reg[LANE_ACCEL_Z];
            result_reg.gravity_norm <= gravity_reg;
            result_reg.tilt_bias_x  <= mean_reg[LANE_TILT_X];
            result_reg.tilt_bias_y  <= mean_reg[LANE_TILT_Y];
            result_reg.rate_done    <= rate_fin_reg;
            result_reg.all_done     <= angle_fin_reg;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    assign accel_means[0] = mean_reg[LANE_ACCEL_X];
    assign accel_means[1] = mean_reg[LANE_ACCEL_Y];
    assign accel_means[2] = mean_reg[LANE_ACCEL_Z];

    imucal_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (acc_ctrl),
        .samples (sample),
        .busy    (acc_busy),
        .sums    (sums)
    );

    imucal_sdiv #(
        .DIVISOR (SAMPLE_COUNT)
    ) u_sdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sums[lane_reg]),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    imucal_gsqrt u_gsqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .accel (accel_means),
        .busy  (sq_busy),
        .done  (sq_done),
        .root  (sq_root)
    );

    // Phase flags only ever set, and phase two never finishes before phase one.
    a_rate_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rate_fin_reg |=> rate_fin_reg)
        else $error("rate_done cleared after being set");

    a_phase_order: assert property (@(posedge clk) disable iff (!rst_n)
        angle_fin_reg |-> rate_fin_reg)
        else $error("angle phase finished before rate phase");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy && !sq_busy)
        else $error("divider started while a serial unit is busy");

    a_acc_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        acc_ctrl.start |-> !acc_busy)
        else $error("accumulator restarted mid-pass");

endmodule

[rtl/core/imucal_accum.sv]
// imucal_accum: eight bit-serial running sums, one full adder per lane.
// Depends on imucal_pkg.
module imucal_accum
    import imucal_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  imucal_acc_ctrl_t ctrl,
    input  imucal_in_t       samples,
    output logic             busy,
    output sum_vec_t         sums
);

    localparam int CNT_W = $clog2(SUM_W);

    sum_vec_t         sum_reg;
    lane_vec_t        sh_reg;
    lane_vec_t        lane_in;
    logic [LANES-1:0] carry_reg;
    logic [LANES-1:0] en_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [LANES-1:0] add_bit;
    logic [LANES-1:0] sum_bit;
    logic [LANES-1:0] carry_next;

    always_comb
    begin
        lane_in[0] = samples.gyro_x;
        lane_in[1] = samples.gyro_y;
        lane_in[2] = samples.gyro_z;
        lane_in[3] = samples.accel_x;
        lane_in[4] = samples.accel_y;
        lane_in[5] = samples.accel_z;
        lane_in[6] = samples.tilt_x;
        lane_in[7] = samples.tilt_y;
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            add_bit[i]    = sh_reg[i][0] & en_reg[i];
            sum_bit[i]    = sum_reg[i][0] ^ add_bit[i] ^ carry_reg[i];
            carry_next[i] = (sum_reg[i][0] & add_bit[i]) | (sum_reg[i][0] & carry_reg[i])
                          | (add_bit[i] & carry_reg[i]);
        end
    end

    // Sums rotate one full turn per request, LSB first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                sum_reg[i] <= {sum_bit[i], sum_reg[i][SUM_W-1:1]};
            end
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SUM_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Sample shifters sign-extend by repeating the top bit.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            sh_reg    <= lane_in;
            carry_reg <= '0;
            en_reg    <= ctrl.lane_en;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                sh_reg[i] <= {sh_reg[i][SAMPLE_W-1], sh_reg[i][SAMPLE_W-1:1]};
            end
            carry_reg <= carry_next;
        end
    end

    assign busy = busy_reg;
    assign sums = sum_reg;

endmodule

[rtl/core/imucal_sdiv.sv]
// imucal_sdiv: serial restoring divide of a signed sum by a fixed count,
// one quotient bit per cycle, truncating toward zero. Depends on imucal_pkg.
module imucal_sdiv
    import imucal_pkg::*;
#(
    parameter int DIVISOR = 100
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [SUM_W-1:0]        dividend,
    output logic                    busy,
    output logic                    done,
    output logic [SAMPLE_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(SUM_W);
    localparam int DIV_W = $clog2(DIVISOR + 1);
    localparam logic [DIV_W:0] DIVISOR_EXT = (DIV_W + 1)'(DIVISOR);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [SUM_W-1:0] dvd_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W:0]   rem_shift;
    logic             fits;
    logic [DIV_W:0]   rem_sub;
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] q_signed;

    assign mag       = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
    assign rem_shift = {rem_reg, dvd_reg[SUM_W-1]};
    assign fits      = (rem_shift >= DIVISOR_EXT);
    assign rem_sub   = rem_shift - DIVISOR_EXT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[SUM_W-1];
            dvd_reg <= mag;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub[DIV_W-1:0] : rem_shift[DIV_W-1:0];
            dvd_reg <= {dvd_reg[SUM_W-2:0], fits};
        end
    end

    assign q_signed = neg_reg ? (~dvd_reg + 1'b1) : dvd_reg;
    assign quotient = q_signed[SAMPLE_W-1:0];
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

[rtl/core/imucal_gsqrt.sv]
// imucal_gsqrt: gravity magnitude from three accelerometer means: serial
// shift-add squares, then a bit-pair integer square root. Depends on imucal_pkg.
module imucal_gsqrt
    import imucal_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  accel_vec_t          accel,
    output logic                busy,
    output logic                done,
    output logic [SAMPLE_W-1:0] root
);

    localparam int CNT_W = $clog2(ROOT_STEPS);

    imucal_sq_state_t    state_reg;
    imucal_sq_state_t    state_next;
    accel_vec_t          mean_reg;
    logic [1:0]          axis_reg;
    logic [SAMPLE_W-1:0] mplier_reg;
    logic [SQ_W-1:0]     mcand_reg;
    logic [SQ_W-1:0]     acc_reg;
    logic [SQ_W-1:0]     root_reg;
    logic [SQ_W-1:0]     bit_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                done_reg;
    logic [SQ_W-1:0]     acc_add;
    logic [SAMPLE_W-1:0] next_mean;
    logic [SAMPLE_W-1:0] next_mag;
    logic [SAMPLE_W-1:0] first_mag;
    logic [SQ_W-1:0]     trial;
    logic                take;
    logic                last_step;

    assign first_mag = accel[0][SAMPLE_W-1] ? (~accel[0] + 1'b1) : accel[0];

    always_comb
    begin
        case (axis_reg)
            2'd0:    next_mean = mean_reg[1];
            default: next_mean = mean_reg[2];
        endcase
    end

    assign next_mag  = next_mean[SAMPLE_W-1] ? (~next_mean + 1'b1) : next_mean;
    assign acc_add   = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign trial     = root_reg + bit_reg;
    assign take      = (acc_reg >= trial);
    assign last_step = (cnt_reg == CNT_W'(ROOT_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SQ_IDLE:
            begin
                if (start)
                begin
                    state_next = SQ_MUL;
                end
            end
            SQ_MUL:
            begin
                if (last_step && axis_reg == 2'd2)
                begin
                    state_next = SQ_ROOT;
                end
            end
            SQ_ROOT:
            begin
                if (last_step)
                begin
                    state_next = SQ_IDLE;
                end
            end
            default: state_next = SQ_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != SQ_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == SQ_ROOT) && last_step;
            if (state_reg == SQ_IDLE)
            begin
                cnt_reg  <= '0;
                axis_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (state_reg == SQ_MUL && last_step)
                begin
                    axis_reg <= axis_reg + 1'b1;
                end
            end
        end
    end

    // Squares accumulate into acc_reg, which then serves as the radicand.
    always_ff @(posedge clk)
    begin
        if (state_reg == SQ_IDLE && start)
        begin
            mean_reg   <= accel;
            mplier_reg <= first_mag;
            mcand_reg  <= SQ_W'(first_mag);
            acc_reg    <= '0;
        end
        else if (state_reg == SQ_MUL)
        begin
            acc_reg <= acc_add;
            if (last_step)
            begin
                mplier_reg <= next_mag;
                mcand_reg  <= SQ_W'(next_mag);
                root_reg   <= '0;
                bit_reg    <= ROOT_FIRST_BIT;
            end
            else
            begin
                mplier_reg <= {1'b0, mplier_reg[SAMPLE_W-1:1]};
                mcand_reg  <= {mcand_reg[SQ_W-2:0], 1'b0};
            end
        end
        else if (state_reg == SQ_ROOT)
        begin
            if (take)
            begin
                acc_reg  <= acc_reg - trial;
                root_reg <= {1'b0, root_reg[SQ_W-1:1]} + bit_reg;
            end
            else
            begin
                root_reg <= {1'b0, root_reg[SQ_W-1:1]};
            end
            bit_reg <= {2'b00, bit_reg[SQ_W-1:2]};
        end
    end

    assign done = done_reg;
    assign root = root_reg[SAMPLE_W-1:0];

endmodule

[test/tb_imu_startup_offset_calibrator_core.sv]
// Self-checking testbench for imu_startup_offset_calibrator_core: drives one full
// calibration (rate averaging, angle lead, tilt window) plus held results after it.
// Depends on imucal_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_imu_startup_offset_calibrator_core;
    import imucal_pkg::*;

    localparam int SAMPLE_COUNT     = 100;
    localparam int ANGLE_LEAD_TICKS = 400;
    localparam int RATE_CNT_W       = $clog2(SAMPLE_COUNT + 1);
    localparam int ANGLE_CNT_W      = $clog2(ANGLE_LEAD_TICKS + 1);
    // The tick that ends phase one and the long output hold-off both wait far less
    // than this limit; anything quiet for longer than that is a hang.
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int DRAIN_CYCLES     = 300;
    localparam int MAX_REPORTS      = 10;

    logic        clk;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_stall;
    imucal_in_t  sample;
    logic        result_valid;
    logic        result_stall;
    imucal_out_t result;

    imu_startup_offset_calibrator_core #(
        .SAMPLE_COUNT     (SAMPLE_COUNT),
        .ANGLE_LEAD_TICKS (ANGLE_LEAD_TICKS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // ------------------------------------------------------------------
    // Calibration state as the testbench sees it. Updated once per accepted
    // request, so it always reflects what the next result must show.
    // ------------------------------------------------------------------
    logic [RATE_CNT_W-1:0]      cal_rate_left;
    logic [ANGLE_CNT_W-1:0]     cal_angle_left;
    logic signed [SUM_W-1:0]    cal_axis_sum  [AXES];
    logic signed [SUM_W-1:0]    cal_tilt_sum  [2];
    logic signed [SAMPLE_W-1:0] cal_axis_mean [AXES];
    logic signed [SAMPLE_W-1:0] cal_tilt_mean [2];
    logic [SAMPLE_W-1:0]        cal_gravity;
    logic                       cal_rate_done;
    logic                       cal_all_done;

    imucal_out_t expected_offsets_q[$];

    int  requests_sent    = 0;
    int  results_checked  = 0;
    int  field_mismatches = 0;
    int  unexpected       = 0;
    int  reports          = 0;
    int  quiet_cycles     = 0;
    int  hold_off_cycles  = 0;
    int  stall_left       = 0;
    bit  sender_gaps_on   = 1'b1;
    bit  receiver_gaps_on = 1'b1;

    always #6 clk = ~clk;

    // Floor square root by setting root bits from the top down.
    function automatic logic [15:0] floor_sqrt32(input logic [31:0] n);
        logic [15:0] root;
        logic [15:0] trial;
        root = '0;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (16'd1 << b);
            if ({16'd0, trial} * {16'd0, trial} <= n)
                root = trial;
        end
        return root;
    endfunction

    // Advance the calibration by one tick and return the offsets it reports.
    function automatic imucal_out_t predict_offsets(input imucal_in_t s);
        logic signed [SAMPLE_W-1:0] axis_in [AXES];
        logic [31:0]                mag_sq;
        logic [15:0]                mag;
        imucal_out_t                r;
        axis_in[0] = s.gyro_x;
        axis_in[1] = s.gyro_y;
        axis_in[2] = s.gyro_z;
        axis_in[3] = s.accel_x;
        axis_in[4] = s.accel_y;
        axis_in[5] = s.accel_z;

        // Phase one: sum rate samples until the countdown runs out, then latch
        // the truncated averages and the gravity magnitude.
        if (!cal_rate_done)
        begin
            for (int i = 0; i < AXES; i++)
                cal_axis_sum[i] = cal_axis_sum[i] + axis_in[i];
            if (cal_rate_left != 0)
                cal_rate_left = cal_rate_left - 1'b1;
            if (cal_rate_left == 0)
            begin
                mag_sq = '0;
                for (int i = 0; i < AXES; i++)
                    cal_axis_mean[i] = SAMPLE_W'(cal_axis_sum[i] / SAMPLE_COUNT);
                for (int i = 3; i < AXES; i++)
                begin
                    mag = (cal_axis_mean[i] < 0) ? -cal_axis_mean[i] : cal_axis_mean[i];
                    mag_sq = mag_sq + {16'd0, mag} * {16'd0, mag};
                end
                cal_gravity   = floor_sqrt32(mag_sq);
                cal_rate_done = 1'b1;
            end
        end

        // Phase two starts on the same tick; only its last SAMPLE_COUNT ticks
        // contribute to the tilt sums.
        if (cal_rate_done && !cal_all_done)
        begin
            if (cal_angle_left != 0)
                cal_angle_left = cal_angle_left - 1'b1;
            if (cal_angle_left < SAMPLE_COUNT)
            begin
                cal_tilt_sum[0] = cal_tilt_sum[0] + s.tilt_x;
                cal_tilt_sum[1] = cal_tilt_sum[1] + s.tilt_y;
                if (cal_angle_left == 0)
                begin
                    cal_tilt_mean[0] = SAMPLE_W'(cal_tilt_sum[0] / SAMPLE_COUNT);
                    cal_tilt_mean[1] = SAMPLE_W'(cal_tilt_sum[1] / SAMPLE_COUNT);
                    cal_all_done     = 1'b1;
                end
            end
        end

        r.gyro_bias_x  = cal_axis_mean[0];
        r.gyro_bias_y  = cal_axis_mean[1];
        r.gyro_bias_z  = cal_axis_mean[2];
        r.accel_bias_x = cal_axis_mean[3];
        r.accel_bias_y = cal_axis_mean[4];
        r.accel_bias_z = cal_axis_mean[5];
        r.gravity_norm = cal_gravity;
        r.tilt_bias_x  = cal_tilt_mean[0];
        r.tilt_bias_y  = cal_tilt_mean[1];
        r.rate_done    = cal_rate_done;
        r.all_done     = cal_all_done;
        return r;
    endfunction

    // Sample near a center, clipped to the 16-bit range.
    function automatic logic [15:0] near_value(input int center, input int spread);
        int v;
        v = center + int'($urandom_range(2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic imucal_in_t any_sample();
        return {$urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    // ------------------------------------------------------------------
    // Request side. Called at a falling edge; returns at a falling edge with
    // sample_valid still high unless an idle burst was taken, so back-to-back
    // requests keep valid asserted. Callers that stop sending use halt_sender.
    // ------------------------------------------------------------------
    task automatic send_sample(input imucal_in_t s);
        sample       <= s;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (sample_stall !== 1'b0)
            @(posedge clk);
        expected_offsets_q.push_back(predict_offsets(s));
        requests_sent++;
        @(negedge clk);
        if (sender_gaps_on && $urandom_range(3) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(18, 1)) @(negedge clk);
        end
    endtask

    task automatic halt_sender();
        sample_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts, plus a long hold-off
    // that a test requests through hold_off_cycles and this process counts.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            stall_left      = hold_off_cycles;
            hold_off_cycles = 0;
        end
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else if (receiver_gaps_on && $urandom_range(5) == 0)
        begin
            result_stall <= 1'b1;
            stall_left = $urandom_range(17, 0);
        end
        else
            result_stall <= 1'b0;
    end

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            field_mismatches++;
            if (reports < MAX_REPORTS)
                $display("[%0t] result %0d: %s expected %h, got %h",
                         $realtime, results_checked, field, want, got);
            reports++;
        end
    endtask

    // Check every delivered result against the oldest outstanding expectation.
    always @(posedge clk)
    begin
        imucal_out_t want;
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (expected_offsets_q.size() == 0)
            begin
                unexpected++;
                if (reports < MAX_REPORTS)
                    $display("[%0t] result with no request outstanding", $realtime);
                reports++;
            end
            else
            begin
                want = expected_offsets_q.pop_front();
                compare_field("gyro_bias_x",  want.gyro_bias_x,  result.gyro_bias_x);
                compare_field("gyro_bias_y",  want.gyro_bias_y,  result.gyro_bias_y);
                compare_field("gyro_bias_z",  want.gyro_bias_z,  result.gyro_bias_z);
                compare_field("accel_bias_x", want.accel_bias_x, result.accel_bias_x);
                compare_field("accel_bias_y", want.accel_bias_y, result.accel_bias_y);
                compare_field("accel_bias_z", want.accel_bias_z, result.accel_bias_z);
                compare_field("gravity_norm", want.gravity_norm, result.gravity_norm);
                compare_field("tilt_bias_x",  want.tilt_bias_x,  result.tilt_bias_x);
                compare_field("tilt_bias_y",  want.tilt_bias_y,  result.tilt_bias_y);
                compare_field("rate_done",    16'(want.rate_done), 16'(result.rate_done));
                compare_field("all_done",     16'(want.all_done),  16'(result.all_done));
                results_checked++;
            end
        end
    end

    // Watchdog: end the run if neither channel completes a handshake for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_stall === 1'b0)
                   || (result_valid === 1'b1 && !result_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                         quiet_cycles, expected_offsets_q.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Open phase one with all-extreme and bit-pattern samples on every field.
    task automatic test_field_extremes();
        imucal_in_t pattern [8];
        pattern[0] = {8{16'h7FFF}};
        pattern[1] = {8{16'h8000}};
        pattern[2] = '0;
        pattern[3] = '1;
        pattern[4] = {8{16'h5555}};
        pattern[5] = {8{16'hAAAA}};
        pattern[6] = {4{16'h7FFF, 16'h8000}};
        pattern[7] = {4{16'h8000, 16'h7FFF}};
        for (int i = 0; i < 8; i++)
            send_sample(pattern[i]);
    endtask

    // Finish phase one with noisy samples around fixed per-axis offsets, so the
    // averages and gravity come out well away from zero; mix in raw noise.
    task automatic test_rate_averaging();
        int         center [AXES];
        imucal_in_t s;
        for (int i = 0; i < AXES; i++)
            center[i] = (i < 3) ? int'($urandom_range(6000)) - 3000
                                : int'($urandom_range(60000)) - 30000;
        while (!cal_rate_done)
        begin
            s = any_sample();
            if ($urandom_range(7) != 0)
            begin
                s.gyro_x  = near_value(center[0], 400);
                s.gyro_y  = near_value(center[1], 400);
                s.gyro_z  = near_value(center[2], 400);
                s.accel_x = near_value(center[3], 400);
                s.accel_y = near_value(center[4], 400);
                s.accel_z = near_value(center[5], 400);
            end
            send_sample(s);
        end
    endtask

    // Hold the result side off for a long stretch while requests keep coming,
    // so the core fills and stalls its input. Rate inputs are ignored by now.
    task automatic test_receiver_backpressure();
        sender_gaps_on  = 1'b0;
        hold_off_cycles = 400;
        repeat (20) send_sample(any_sample());
        sender_gaps_on  = 1'b1;
    endtask

    // Run out the angle lead up to the start of the tilt window.
    task automatic test_lead_ticks();
        while (cal_angle_left > SAMPLE_COUNT)
            send_sample(any_sample());
    endtask

    // Pause the request side until every outstanding result has come back.
    task automatic test_drain_pause();
        halt_sender();
        while (expected_offsets_q.size() != 0)
            @(negedge clk);
    endtask

    // Fill the tilt window: extremes first, then noise around fixed angles.
    task automatic test_tilt_window();
        imucal_in_t s;
        int         tilt_center_x;
        int         tilt_center_y;
        tilt_center_x = int'($urandom_range(16000)) - 8000;
        tilt_center_y = int'($urandom_range(16000)) - 8000;
        s = any_sample();
        s.tilt_x = 16'sh7FFF;
        s.tilt_y = 16'sh7FFF;
        send_sample(s);
        s = any_sample();
        s.tilt_x = 16'sh8000;
        s.tilt_y = 16'sh8000;
        send_sample(s);
        while (!cal_all_done)
        begin
            s = any_sample();
            if ($urandom_range(9) != 0)
            begin
                s.tilt_x = near_value(tilt_center_x, 200);
                s.tilt_y = near_value(tilt_center_y, 200);
            end
            send_sample(s);
        end
    endtask

    // After both phases every result must hold; drop all idling near the end.
    task automatic test_hold_after_done();
        for (int n = 0; n < 400; n++)
        begin
            if (n == 340)
            begin
                sender_gaps_on   = 1'b0;
                receiver_gaps_on = 1'b0;
            end
            send_sample(any_sample());
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        result_stall = 1'b0;

        cal_rate_left  = RATE_CNT_W'(SAMPLE_COUNT);
        cal_angle_left = ANGLE_CNT_W'(ANGLE_LEAD_TICKS);
        for (int i = 0; i < AXES; i++)
        begin
            cal_axis_sum[i]  = '0;
            cal_axis_mean[i] = '0;
        end
        for (int i = 0; i < 2; i++)
        begin
            cal_tilt_sum[i]  = '0;
            cal_tilt_mean[i] = '0;
        end
        cal_gravity   = '0;
        cal_rate_done = 1'b0;
        cal_all_done  = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_field_extremes();
        test_rate_averaging();
        test_receiver_backpressure();
        test_lead_ticks();
        test_drain_pause();
        test_tilt_window();
        test_hold_after_done();

        // Drain, then leave room for any stray result to show up.
        halt_sender();
        while (expected_offsets_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d requests, %0d results checked over both calibration phases",
                 requests_sent, results_checked);
        $display("  (extreme samples, 400-cycle output hold-off, drain pause, held results)");
        if (field_mismatches == 0 && unexpected == 0 && expected_offsets_q.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d field mismatches, %0d unexpected results, %0d missing",
                     field_mismatches, unexpected, expected_offsets_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
